FILE: sv/text_console_writer_defines.svh
// Assertion macros for a file that checks its own logic.
`ifndef TEXT_CONSOLE_WRITER_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_DEFINES_SVH

`ifndef SYNTHESIS

`define TCW_ASSERT_IMPLIES(label, clk, rst, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error("text console writer: same-cycle check failed");

`define TCW_ASSERT_NEXT(label, clk, rst, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error("text console writer: next-cycle check failed");

`else

`define TCW_ASSERT_IMPLIES(label, clk, rst, cond, expr)

`define TCW_ASSERT_NEXT(label, clk, rst, cond, expr)

`endif

`endif

FILE: sv/tcw_pkg.sv
package tcw_pkg;

  localparam int DEF_COLUMNS = 80;
  localparam int DEF_ROWS    = 25;

  localparam int KIND_W = 2;
  localparam int CHAR_W = 8;
  localparam int ATTR_W = 8;
  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int OFF_W  = 11;

  localparam int S_TDATA_W = 32;
  localparam int M_TDATA_W = 40;

  localparam logic [CHAR_W-1:0] CODE_BACKSPACE = 8'h08;
  localparam logic [CHAR_W-1:0] CODE_NEWLINE   = 8'h0A;

  typedef enum logic [KIND_W-1:0] {
    KIND_PUT   = 2'd0,
    KIND_CLEAR = 2'd1,
    KIND_SET   = 2'd2,
    KIND_READ  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    WR_NONE = 2'd0,
    WR_PUT  = 2'd1,
    WR_FILL = 2'd2,
    WR_MOVE = 2'd3
  } wr_op_t;

  typedef struct packed {
    logic   latch;
    wr_op_t wr_op;
    logic   fill_attr;
    logic   cur_put;
    logic   cur_home;
    logic   cur_set;
    logic   out_load;
  } tcw_cmd_t;

  typedef struct packed {
    kind_t kind;
    logic  wraps;
    logic  move_last;
    logic  cell_last;
    logic  out_free;
  } tcw_status_t;

endpackage

FILE: sv/text_console_writer.sv
// Text-mode screen engine over a COLUMNS x ROWS buffer of 16-bit cells.
// Items arrive on the s_axis word channel: tuser carries the kind (put,
// clear, set cursor, read) and tdata the character, attribute, column and
// row. Each item yields exactly one word on m_axis with the cursor column,
// row and linear offset, the scrolled flag in tuser and, for a read, the cell.
// A put, set-cursor or read item passes its put or query state, then the
// result state loads the output register; the cell store has one write
// and one registered read port. A put that runs past the last row then
// scrolls: each row moves up one cell per cycle through the read port,
// then the bottom row is zeroed. A clear item fills every cell, one cell
// per cycle. After reset a clearing pass writes zero to every cell, during
// which s_axis_tready stays low. The result waits in an output register;
// while m_axis_tready is low the next item is still accepted and worked
// on, and its result waits until the register is free.
`include "text_console_writer_defines.svh"

module text_console_writer
  import tcw_pkg::*;
#(
  parameter int COLUMNS = DEF_COLUMNS,
  parameter int ROWS    = DEF_ROWS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // char_code[7:0], attribute[15:8], col[22:16], row[27:23], zero pad
  input  logic [S_TDATA_W-1:0] s_axis_tdata,
  // kind[1:0]
  input  logic [KIND_W-1:0]    s_axis_tuser,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // cursor_col[6:0], cursor_row[11:7], cursor_offset[22:12],
  // cell_char[30:23], cell_attribute[38:31], zero pad
  output logic [M_TDATA_W-1:0] m_axis_tdata,
  // scrolled[0]
  output logic [0:0]           m_axis_tuser
);

  tcw_cmd_t    cmd;
  tcw_status_t st;

  tcw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_kind  (kind_t'(s_axis_tuser)),
    .in_ready (s_axis_tready),
    .cmd      (cmd),
    .st       (st)
  );

  tcw_datapath #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_tdata  (s_axis_tdata),
    .in_tuser  (s_axis_tuser),
    .cmd       (cmd),
    .st        (st),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_tdata (m_axis_tdata),
    .out_tuser (m_axis_tuser[0])
  );

  `TCW_ASSERT_NEXT(a_accept_then_busy, clk, rst, s_axis_tvalid && s_axis_tready, !s_axis_tready)
  `TCW_ASSERT_IMPLIES(a_no_result_overwrite, clk, rst, cmd.out_load, st.out_free)
  `TCW_ASSERT_IMPLIES(a_scroll_col_zero, clk, rst, m_axis_tvalid && m_axis_tuser[0], m_axis_tdata[COL_W-1:0] == '0)

endmodule

FILE: sv/tcw_ctrl.sv
module tcw_ctrl
  import tcw_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  kind_t       in_kind,
  output logic        in_ready,
  output tcw_cmd_t    cmd,
  input  tcw_status_t st
);

  typedef enum logic [7:0] {
    ST_INIT   = 8'b0000_0001,
    ST_IDLE   = 8'b0000_0010,
    ST_PUT    = 8'b0000_0100,
    ST_FILL   = 8'b0000_1000,
    ST_MOVE   = 8'b0001_0000,
    ST_BOTTOM = 8'b0010_0000,
    ST_QUERY  = 8'b0100_0000,
    ST_RESULT = 8'b1000_0000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.wr_op  = WR_NONE;
    in_ready   = 1'b0;
    unique case (state)
      ST_INIT: begin
        cmd.wr_op = WR_FILL;
        if (st.cell_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch = 1'b1;
          unique case (in_kind)
            KIND_PUT:   state_next = ST_PUT;
            KIND_CLEAR: state_next = ST_FILL;
            KIND_SET:   state_next = ST_QUERY;
            KIND_READ:  state_next = ST_QUERY;
            default:    state_next = ST_QUERY;
          endcase
        end
      end
      ST_PUT: begin
        cmd.wr_op   = WR_PUT;
        cmd.cur_put = 1'b1;
        state_next  = st.wraps ? ST_MOVE : ST_RESULT;
      end
      ST_FILL: begin
        cmd.wr_op     = WR_FILL;
        cmd.fill_attr = 1'b1;
        if (st.cell_last) begin
          cmd.cur_home = 1'b1;
          state_next   = ST_RESULT;
        end
      end
      ST_MOVE: begin
        cmd.wr_op = WR_MOVE;
        if (st.move_last) begin
          state_next = ST_BOTTOM;
        end
      end
      ST_BOTTOM: begin
        cmd.wr_op = WR_FILL;
        if (st.cell_last) begin
          state_next = ST_RESULT;
        end
      end
      ST_QUERY: begin
        cmd.cur_set = (st.kind == KIND_SET);
        state_next  = ST_RESULT;
      end
      ST_RESULT: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_INIT;
      end
    endcase
  end

endmodule

FILE: sv/tcw_datapath.sv
module tcw_datapath
  import tcw_pkg::*;
#(
  parameter int COLUMNS = DEF_COLUMNS,
  parameter int ROWS    = DEF_ROWS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [S_TDATA_W-1:0] in_tdata,
  input  logic [KIND_W-1:0]    in_tuser,
  input  tcw_cmd_t             cmd,
  output tcw_status_t          st,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [M_TDATA_W-1:0] out_tdata,
  output logic                 out_tuser
);

  localparam int CELLS  = COLUMNS * ROWS;
  localparam int XW     = $clog2(COLUMNS);
  localparam int YW     = $clog2(ROWS);
  localparam int AW     = $clog2(CELLS);
  localparam int CELL_W = CHAR_W + ATTR_W;
  localparam int QXW    = (XW > COL_W) ? XW : COL_W;
  localparam int QYW    = (YW > ROW_W) ? YW : ROW_W;

  localparam logic [XW-1:0] X_MAX     = XW'(COLUMNS - 1);
  localparam logic [YW-1:0] Y_MAX     = YW'(ROWS - 1);
  localparam logic [AW-1:0] ROW_STEP  = AW'(COLUMNS);
  localparam logic [AW-1:0] MOVE_LAST = AW'(COLUMNS * (ROWS - 1) - 1);
  localparam logic [AW-1:0] CELL_LAST = AW'(CELLS - 1);

  logic [CHAR_W-1:0] in_char;
  logic [ATTR_W-1:0] in_attr;
  logic [COL_W-1:0]  in_col;
  logic [ROW_W-1:0]  in_row;

  kind_t             kind_l;
  logic [CHAR_W-1:0] char_l;
  logic [ATTR_W-1:0] attr_l;
  logic [XW-1:0]     qx;
  logic [YW-1:0]     qy;

  logic [XW-1:0]     x;
  logic [YW-1:0]     y;
  logic              scrolled;
  logic [XW-1:0]     x_put;
  logic [YW-1:0]     y_put;
  logic              wraps;
  logic              printable;

  logic [AW-1:0]     cnt;
  logic [AW-1:0]     cur_addr;
  logic [AW-1:0]     q_addr;
  logic [AW-1:0]     rd_addr;

  logic              wr_pend;
  logic              wr_move;
  logic [AW-1:0]     wr_addr;
  logic [CELL_W-1:0] wr_word;
  logic [CELL_W-1:0] rd_q;
  logic [CELL_W-1:0] mem [CELLS];

  logic [CELL_W-1:0] cell_out;
  logic              issue_cnt;

  assign in_char = in_tdata[CHAR_W-1:0];
  assign in_attr = in_tdata[CHAR_W+ATTR_W-1:CHAR_W];
  assign in_col  = in_tdata[CHAR_W+ATTR_W+COL_W-1:CHAR_W+ATTR_W];
  assign in_row  = in_tdata[CHAR_W+ATTR_W+COL_W+ROW_W-1:CHAR_W+ATTR_W+COL_W];

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      kind_l <= kind_t'(in_tuser);
      char_l <= in_char;
      attr_l <= in_attr;
      qx     <= (QXW'(in_col) > QXW'(COLUMNS - 1)) ? X_MAX : XW'(in_col);
      qy     <= (QYW'(in_row) > QYW'(ROWS - 1)) ? Y_MAX : YW'(in_row);
    end
  end

  assign printable = (char_l != CODE_BACKSPACE) && (char_l != CODE_NEWLINE);

  always_comb begin
    x_put = x;
    y_put = y;
    wraps = 1'b0;
    priority if (char_l == CODE_BACKSPACE) begin
      if (x != '0) begin
        x_put = x - XW'(1);
      end
    end else if (char_l == CODE_NEWLINE || x == X_MAX) begin
      x_put = '0;
      if (y == Y_MAX) begin
        wraps = 1'b1;
      end else begin
        y_put = y + YW'(1);
      end
    end else begin
      x_put = x + XW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      x        <= '0;
      y        <= '0;
      scrolled <= 1'b0;
    end else begin
      if (cmd.cur_put) begin
        x <= x_put;
        y <= y_put;
      end else if (cmd.cur_home) begin
        x <= '0;
        y <= '0;
      end else if (cmd.cur_set) begin
        x <= qx;
        y <= qy;
      end
      if (cmd.latch) begin
        scrolled <= 1'b0;
      end else if (cmd.cur_put) begin
        scrolled <= wraps;
      end
    end
  end

  assign cur_addr  = AW'(y) * ROW_STEP + AW'(x);
  assign q_addr    = AW'(qy) * ROW_STEP + AW'(qx);
  assign rd_addr   = (cmd.wr_op == WR_MOVE) ? cnt + ROW_STEP : q_addr;
  assign issue_cnt = (cmd.wr_op == WR_FILL) || (cmd.wr_op == WR_MOVE);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt     <= '0;
      wr_pend <= 1'b0;
    end else begin
      if (cmd.latch) begin
        cnt <= '0;
      end else if (issue_cnt) begin
        cnt <= cnt + AW'(1);
      end
      wr_pend <= issue_cnt || (cmd.wr_op == WR_PUT && printable);
    end
  end

  always_ff @(posedge clk) begin
    wr_move <= (cmd.wr_op == WR_MOVE);
    wr_addr <= (cmd.wr_op == WR_PUT) ? cur_addr : cnt;
    if (cmd.wr_op == WR_PUT) begin
      wr_word <= {attr_l, char_l};
    end else if (cmd.fill_attr) begin
      wr_word <= {attr_l, CHAR_W'(0)};
    end else begin
      wr_word <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_pend) begin
      mem[wr_addr] <= wr_move ? rd_q : wr_word;
    end
    rd_q <= mem[rd_addr];
  end

  assign cell_out = (kind_l == KIND_READ) ? rd_q : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_tdata <= M_TDATA_W'({cell_out, OFF_W'(cur_addr), ROW_W'(y), COL_W'(x)});
      out_tuser <= scrolled;
    end
  end

  assign st.kind      = kind_l;
  assign st.wraps     = wraps;
  assign st.move_last = (cnt == MOVE_LAST);
  assign st.cell_last = (cnt == CELL_LAST);
  assign st.out_free  = !out_valid || out_ready;

endmodule
